// ===== hdl/utf8s_pkg.sv =====
// Package for the UTF-8 byte sanitizer: byte, emit and held-byte types,
// lead-byte constants and the lead-length decode function.
// No dependencies.
package utf8s_pkg;

   // Replacement character written for each rejected lead byte or unfinished sequence
   localparam logic [7:0] REPL_CHAR = 8'h3F;

   // Lead and continuation byte masks and codes
   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;

   // Most results one transaction can cause, most bytes held between transactions
   localparam int MAX_OUT  = 4;
   localparam int MAX_HELD = 3;

   typedef logic [7:0] byte_type;

   // Results of one transaction, oldest in slot 0
   typedef struct packed {
      byte_type [MAX_OUT-1:0] data;
      logic     [MAX_OUT-1:0] last;
      logic     [2:0]         count;
   } emit_type;

   // Bytes of an unfinished sequence, oldest in slot 0
   typedef struct packed {
      byte_type [MAX_HELD-1:0] data;
      logic     [1:0]          count;
   } held_type;

   // Sequence length from the lead byte, zero for a byte that cannot lead
   function automatic logic [2:0] lead_length(input byte_type c);
      logic [2:0] len;
      if (c < ASCII_LIMIT) begin
         len = 3'd1;
      end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
         len = 3'd2;
      end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
         len = 3'd3;
      end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic logic is_cont(input byte_type c);
      return (c & CONT_MASK) == CONT_CODE;
   endfunction

endpackage

// ===== hdl/utf8s_decode.sv =====
// Single-pass scan of the held bytes plus one new byte: emits up to four
// cleaned bytes and the bytes left to hold. Depends on utf8s_pkg.
module utf8s_decode (
   input  utf8s_pkg::held_type held,
   input  utf8s_pkg::byte_type in_byte,
   input  logic                in_last,
   output utf8s_pkg::emit_type emit,
   output utf8s_pkg::held_type held_next
);
   import utf8s_pkg::*;

   // Scan the window from the oldest byte; each step consumes at least one byte or ends the scan
   always_comb begin
      byte_type   q [MAX_OUT];
      logic [2:0] n;
      logic [2:0] pos;
      logic [2:0] len;
      logic [2:0] k;
      logic [2:0] idx;
      logic       done;
      logic       ok;

      // Build the window: held bytes, then the new byte
      for (int i = 0; i < MAX_HELD; i++) begin
         q[i] = (2'(i) < held.count) ? held.data[i] : in_byte;
      end
      q[MAX_OUT-1] = in_byte;
      n    = {1'b0, held.count} + 3'd1;
      pos  = '0;
      k    = '0;
      done = 1'b0;
      len  = '0;
      ok   = 1'b0;
      idx  = '0;
      emit.data = '0;
      emit.last = '0;

      for (int s = 0; s < MAX_OUT; s++) begin
         if (!done && pos < n) begin
            len = lead_length(q[pos[1:0]]);
            if (len == 3'd0) begin
               // Replace a byte that cannot lead
               emit.data[k[1:0]] = REPL_CHAR;
               k   = k + 3'd1;
               pos = pos + 3'd1;
            end else if ((n - pos) < len) begin
               // Hold an unfinished sequence, or replace it at string end
               if (in_last) begin
                  emit.data[k[1:0]] = REPL_CHAR;
                  k   = k + 3'd1;
                  pos = n;
               end
               done = 1'b1;
            end else begin
               ok = 1'b1;
               for (int j = 1; j < MAX_OUT; j++) begin
                  idx = pos + 3'(j);
                  if (3'(j) < len && !is_cont(q[idx[1:0]])) begin
                     ok = 1'b0;
                  end
               end
               if (ok) begin
                  // Copy the whole sequence
                  for (int j = 0; j < MAX_OUT; j++) begin
                     if (3'(j) < len) begin
                        idx = pos + 3'(j);
                        emit.data[2'(k + 3'(j))] = q[idx[1:0]];
                     end
                  end
                  k   = k + len;
                  pos = pos + len;
               end else begin
                  // Replace the lead only and rescan what follows
                  emit.data[k[1:0]] = REPL_CHAR;
                  k   = k + 3'd1;
                  pos = pos + 3'd1;
               end
            end
         end
      end

      emit.count = k;
      for (int i = 0; i < MAX_OUT; i++) begin
         emit.last[i] = in_last && (k != 3'd0) && (3'(i) == k - 3'd1);
      end

      // Keep what is left unless the string ended
      for (int i = 0; i < MAX_HELD; i++) begin
         idx = pos + 3'(i);
         held_next.data[i] = q[idx[1:0]];
      end
      idx = n - pos;
      held_next.count = in_last ? 2'd0 : idx[1:0];
   end

endmodule

// ===== hdl/utf8s_out_fifo.sv =====
// Result queue: takes up to four results in one cycle, hands out one a cycle while pop is high.
// Depends on utf8s_pkg.
module utf8s_out_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utf8s_pkg::emit_type emit,
   input  logic                pop,
   output logic                space_ok,
   output logic                out_valid,
   output utf8s_pkg::byte_type out_byte,
   output logic                out_last
);
   import utf8s_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   byte_type        data_ff [DEPTH];
   logic            last_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   push_n;
   logic [AW-1:0]   slot [MAX_OUT];

   // Room for a full burst of results
   assign space_ok  = count_ff <= CW'(DEPTH - MAX_OUT);
   assign out_valid = count_ff != '0;
   assign out_byte  = data_ff[rd_ptr_ff];
   assign out_last  = last_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      push_n    = push ? CW'(emit.count) : '0;
      wr_ptr_in = wr_ptr_ff + AW'(push_n);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + push_n - CW'(pop);
      for (int i = 0; i < MAX_OUT; i++) begin
         slot[i] = wr_ptr_ff + AW'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the new results at consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_OUT; i++) begin
         if (push && 3'(i) < emit.count) begin
            data_ff[slot[i]] <= emit.data[i];
            last_ff[slot[i]] <= emit.last[i];
         end
      end
   end

endmodule

// ===== hdl/utf8_byte_sanitizer_top.sv =====
// Top level of the UTF-8 byte sanitizer: input register, held-byte state,
// scan logic and result queue. Depends on utf8s_pkg, utf8s_decode, utf8s_out_fifo.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_byte[7:0], req_last
//   rsp     | out       | rsp_valid / rsp_ready | rsp_byte[7:0], rsp_last
//
// One byte is taken each cycle while the result queue has room for four results;
// a taken byte waits in the input register until the queue has that room, and its results
// are then written into the queue, whose registered fill level drives rsp_valid.
// A transaction gives zero to four results, never more results than bytes overall.
// The result queue (OUT_DEPTH, a power of two, at least 8) sets how long bursts last.
// Synchronous reset empties the input register, the held bytes and the queue.
// A stall on rsp fills the queue, then holds req_ready low.
module utf8_byte_sanitizer_top #(
   parameter int OUT_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);
   import utf8s_pkg::*;

   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;
   logic     in_last_ff;
   byte_type [MAX_HELD-1:0] held_data_ff;
   logic     [1:0]          held_count_ff, held_count_in;
   held_type held;
   held_type held_next;
   emit_type emit;
   logic     space_ok;
   logic     commit;
   logic     req_accept;

   assign held.data  = held_data_ff;
   assign held.count = held_count_ff;

   // Retire the registered byte when the queue can take its results
   assign commit     = in_valid_ff && space_ok;
   assign req_ready  = !in_valid_ff || commit;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in   = req_accept ? 1'b1 : (commit ? 1'b0 : in_valid_ff);
      held_count_in = commit ? held_next.count : held_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         held_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         held_count_ff <= held_count_in;
      end
   end

   // Capture the new byte and the bytes still held
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_byte;
         in_last_ff <= req_last;
      end
      if (commit) begin
         held_data_ff <= held_next.data;
      end
   end

   utf8s_decode u_decode (
      .held      (held),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .emit      (emit),
      .held_next (held_next)
   );

   utf8s_out_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (commit),
      .emit      (emit),
      .pop       (rsp_valid && rsp_ready),
      .space_ok  (space_ok),
      .out_valid (rsp_valid),
      .out_byte  (rsp_byte),
      .out_last  (rsp_last)
   );

endmodule

// ===== hdl/utf8s_checker.sv =====
// Port-level checks for the UTF-8 byte sanitizer, bound to its top level.
// Depends on utf8_byte_sanitizer_top.
module utf8s_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_byte,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);

   // Come out of reset empty and ready
   assert property (@(posedge clock) reset |=> (!rsp_valid && req_ready))
      else $error("not empty and ready after reset");

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_byte) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // Never pass a byte that cannot lead or continue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte[7:3] != 5'b11111)
      else $error("illegal byte passed through");

   // Never end a string on a multi-byte lead
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_byte[7:6] != 2'b11)
      else $error("string ends on a lead byte");

endmodule

bind utf8_byte_sanitizer_top utf8s_checker u_checker (.*);
